### sv/vng_pkg.sv
package vng_pkg;

  // Request codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  // Configuration register indexes
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  localparam int unsigned CFG_W       = 13;
  localparam int unsigned COORD_W     = 12;
  localparam int unsigned PIX_W       = 16;
  localparam int unsigned NOISE_SIDE  = 256;
  localparam int unsigned NOISE_AW    = 16;
  localparam int unsigned NOISE_DEPTH = NOISE_SIDE * NOISE_SIDE;

  // Power tables: 16-bit index, 16-bit entry
  localparam int unsigned TBL_AW    = 16;
  localparam int unsigned TBL_DEPTH = 1 << TBL_AW;
  localparam logic [TBL_AW-1:0] TBL_LAST = {TBL_AW{1'b1}};

  localparam int unsigned CFG_RESET_WIDTH  = 1920;
  localparam int unsigned CFG_RESET_HEIGHT = 1080;

  // Width of elaboration-time difference arithmetic
  localparam int unsigned DIFF_W = 192;

  // Table sweep write port
  typedef struct packed {
    logic              en;
    logic [TBL_AW-1:0] addr;
    logic [PIX_W-1:0]  data;
  } tbl_wr_t;

  function automatic logic [DIFF_W-1:0] ipow(input int unsigned base, input int unsigned e);
    logic [DIFF_W-1:0] r;
    r = DIFF_W'(1);
    for (int unsigned i = 0; i < e; i++) r = r * DIFF_W'(base);
    return r;
  endfunction

  // j-th forward difference of x^k at x0, modulo 2^DIFF_W
  function automatic logic [DIFF_W-1:0] fwd_diff(input int unsigned k, input int unsigned j,
                                                 input int unsigned x0);
    logic [DIFF_W-1:0] v [0:15];
    for (int unsigned i = 0; i < 16; i++) v[i] = ipow(x0 + i, k);
    for (int unsigned r = 0; r < j; r++) begin
      for (int unsigned i = 0; i + r + 1 <= j; i++) v[i] = v[i+1] - v[i];
    end
    return v[0];
  endfunction

  localparam logic [DIFF_W-1:0] GAMMA_RHS_C = ipow(65535, 6);
  localparam logic [DIFF_W-1:0] VIG_RHS_C   = DIFF_W'(1) << 64;

endpackage

### sv/vng_ram.sv
module vng_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  // Registered read, hold when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_o <= mem[raddr_i];
  end

endmodule

### sv/vng_pow_sweep.sv
// Fills a table with y(x) = largest y such that y^DEN <= RHS_C * x^NUM,
// walking x and y upwards with forward differences of both sides.
module vng_pow_sweep
  import vng_pkg::*;
#(
  parameter int unsigned       ACC_W = 180,
  parameter int unsigned       DEN   = 11,
  parameter int unsigned       NUM   = 5,
  parameter logic [DIFF_W-1:0] RHS_C = GAMMA_RHS_C
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  output tbl_wr_t wr_o,
  output logic    done_o
);

  logic              busy_q;
  logic [TBL_AW-1:0] idx_q, idx_d;
  logic [PIX_W-1:0]  y_q, y_d;
  logic [ACC_W-1:0]  fd_q [0:DEN];
  logic [ACC_W-1:0]  fd_d [0:DEN];
  logic [ACC_W-1:0]  gd_q [0:NUM];
  logic [ACC_W-1:0]  gd_d [0:NUM];
  logic              step_y;

  // Advance y while (y+1)^DEN still fits under the right-hand side
  assign step_y = (fd_q[0] <= gd_q[0]);

  always_comb begin
    fd_d = fd_q;
    gd_d = gd_q;
    y_d  = y_q;
    idx_d = idx_q;
    if (step_y) begin
      y_d = y_q + PIX_W'(1);
      for (int j = 0; j < DEN; j++) fd_d[j] = fd_q[j] + fd_q[j+1];
    end else begin
      idx_d = idx_q + TBL_AW'(1);
      for (int j = 0; j < NUM; j++) gd_d[j] = gd_q[j] + gd_q[j+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      y_q    <= '0;
      for (int j = 0; j <= DEN; j++) fd_q[j] <= ACC_W'(fwd_diff(DEN, j, 1));
      for (int j = 0; j <= NUM; j++) gd_q[j] <= ACC_W'(RHS_C * fwd_diff(NUM, j, 0));
    end else if (busy_q) begin
      y_q   <= y_d;
      idx_q <= idx_d;
      fd_q  <= fd_d;
      gd_q  <= gd_d;
      if (!step_y && idx_q == TBL_LAST) busy_q <= 1'b0;
    end
  end

  assign wr_o.en   = busy_q && !step_y;
  assign wr_o.addr = idx_q;
  assign wr_o.data = y_q;
  assign done_o    = !busy_q;

endmodule

### sv/vignette_noise_gamma_pixel_stage.sv
// Throughput: one request per cycle once the tables are built; then the stream only stops when the output stalls.
// Load requests write the noise table at acceptance and give no result.
// After reset the fifth-root and gamma tables are built, one table entry or one root step
// per cycle; no request is taken meanwhile.
// Reset restores width 1920 and height 1080; the noise table is not cleared.
module vignette_noise_gamma_pixel_stage
  import vng_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_addr_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [NOISE_AW-1:0] noise_addr_i,
  input  logic [PIX_W-1:0]   noise_value_i,
  input  logic [COORD_W-1:0] pixel_row_i,
  input  logic [COORD_W-1:0] pixel_col_i,
  input  logic [PIX_W-1:0]   red_in_i,
  input  logic [PIX_W-1:0]   green_in_i,
  input  logic [PIX_W-1:0]   blue_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PIX_W-1:0]   red_out_o,
  output logic [PIX_W-1:0]   green_out_o,
  output logic [PIX_W-1:0]   blue_out_o
);

  localparam int unsigned NST = 23;

  typedef struct packed {
    logic [PIX_W-1:0] red, green, blue;
    logic [CFG_W-1:0] ru, rv;
    logic [15:0]      qu, qv;
    logic             satu, satv;
    logic [15:0]      wa, wb;
    logic [31:0]      r1, r2;
    logic [47:0]      pa, pb;
    logic [15:0]      n;
    logic [39:0]      sx;
    logic [15:0]      s;
    logic [16:0]      gu, gv, t;
    logic [15:0]      p;
    logic [15:0]      mr, mg, mb;
  } pix_t;

  typedef struct packed {
    logic [CFG_W-1:0] rem;
    logic [15:0]      q;
  } div_t;

  logic [CFG_W-1:0] width_q, height_q, wdiv, hdiv;
  pix_t             st_q [1:NST];
  pix_t             st_d [1:NST];
  logic [NST:1]     vld_q;
  logic             adv, accept, ready;
  logic             gam_done, vig_done;
  tbl_wr_t          gam_wr, vig_wr;

  logic [7:0]  ry1, ry2, cx1, cx2;
  logic [15:0] rpos, cpos;
  logic [15:0] n11, n12, n21, n22, vig_rd;
  logic        load_we;

  // One restoring division step: shift, compare, subtract
  function automatic div_t div_step(input logic [CFG_W-1:0] rem, input logic [15:0] q,
                                    input logic [CFG_W-1:0] d);
    div_t        r;
    logic [CFG_W:0] sh;
    sh = {rem, 1'b0};
    if (sh >= {1'b0, d}) begin
      r.rem = CFG_W'(sh - {1'b0, d});
      r.q   = {q[14:0], 1'b1};
    end else begin
      r.rem = sh[CFG_W-1:0];
      r.q   = {q[14:0], 1'b0};
    end
    return r;
  endfunction

  // u*(1-u) >> 14, with u and the result in Q1.16
  function automatic logic [16:0] edge_gain(input logic sat, input logic [15:0] q);
    logic [16:0] u;
    logic [33:0] pr;
    u  = sat ? 17'h10000 : {1'b0, q};
    pr = 34'(u) * 34'(17'h10000 - u);
    return pr[30:14];
  endfunction

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(CFG_RESET_WIDTH);
      height_q <= CFG_W'(CFG_RESET_HEIGHT);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign wdiv = (width_q == '0)  ? CFG_W'(1) : width_q;
  assign hdiv = (height_q == '0) ? CFG_W'(1) : height_q;

  // Handshake: the whole pipe moves unless the output is held
  assign ready      = gam_done && vig_done;
  assign adv        = !vld_q[NST] || !out_stall_i;
  assign in_stall_o = !ready || !adv;
  assign accept     = in_valid_i && !in_stall_o;
  assign load_we    = accept && (cmd_i == CMD_LOAD);

  // Noise grid positions of the bilinear corners
  assign rpos = {8'd0, pixel_row_i[7:0]} * 16'd255;
  assign cpos = {8'd0, pixel_col_i[7:0]} * 16'd255;
  assign ry1  = rpos[15:8];
  assign cx1  = cpos[15:8];
  assign ry2  = (ry1 == 8'hFF) ? ry1 : ry1 + 8'd1;
  assign cx2  = (cx1 == 8'hFF) ? cx1 : cx1 + 8'd1;

  // Four copies of the noise table, one per corner
  vng_ram #(.WIDTH(PIX_W), .DEPTH(NOISE_DEPTH)) u_noise11 (
    .clk_i, .we_i(load_we), .waddr_i(noise_addr_i), .wdata_i(noise_value_i),
    .re_i(adv), .raddr_i({ry1, cx1}), .rdata_o(n11));
  vng_ram #(.WIDTH(PIX_W), .DEPTH(NOISE_DEPTH)) u_noise12 (
    .clk_i, .we_i(load_we), .waddr_i(noise_addr_i), .wdata_i(noise_value_i),
    .re_i(adv), .raddr_i({ry1, cx2}), .rdata_o(n12));
  vng_ram #(.WIDTH(PIX_W), .DEPTH(NOISE_DEPTH)) u_noise21 (
    .clk_i, .we_i(load_we), .waddr_i(noise_addr_i), .wdata_i(noise_value_i),
    .re_i(adv), .raddr_i({ry2, cx1}), .rdata_o(n21));
  vng_ram #(.WIDTH(PIX_W), .DEPTH(NOISE_DEPTH)) u_noise22 (
    .clk_i, .we_i(load_we), .waddr_i(noise_addr_i), .wdata_i(noise_value_i),
    .re_i(adv), .raddr_i({ry2, cx2}), .rdata_o(n22));

  // Build the fifth-root and gamma tables after reset
  vng_pow_sweep #(.ACC_W(84), .DEN(5), .NUM(1), .RHS_C(VIG_RHS_C)) u_vig_sweep (
    .clk_i, .rst_ni, .wr_o(vig_wr), .done_o(vig_done));
  vng_pow_sweep #(.ACC_W(180), .DEN(11), .NUM(5), .RHS_C(GAMMA_RHS_C)) u_gam_sweep (
    .clk_i, .rst_ni, .wr_o(gam_wr), .done_o(gam_done));

  vng_ram #(.WIDTH(PIX_W), .DEPTH(TBL_DEPTH)) u_vig_tbl (
    .clk_i, .we_i(vig_wr.en), .waddr_i(vig_wr.addr), .wdata_i(vig_wr.data),
    .re_i(adv), .raddr_i(st_q[19].t[15:0]), .rdata_o(vig_rd));
  vng_ram #(.WIDTH(PIX_W), .DEPTH(TBL_DEPTH)) u_gam_red (
    .clk_i, .we_i(gam_wr.en), .waddr_i(gam_wr.addr), .wdata_i(gam_wr.data),
    .re_i(adv), .raddr_i(st_q[22].mr), .rdata_o(red_out_o));
  vng_ram #(.WIDTH(PIX_W), .DEPTH(TBL_DEPTH)) u_gam_green (
    .clk_i, .we_i(gam_wr.en), .waddr_i(gam_wr.addr), .wdata_i(gam_wr.data),
    .re_i(adv), .raddr_i(st_q[22].mg), .rdata_o(green_out_o));
  vng_ram #(.WIDTH(PIX_W), .DEPTH(TBL_DEPTH)) u_gam_blue (
    .clk_i, .we_i(gam_wr.en), .waddr_i(gam_wr.addr), .wdata_i(gam_wr.data),
    .re_i(adv), .raddr_i(st_q[22].mb), .rdata_o(blue_out_o));

  // Pipeline stage logic
  always_comb begin
    div_t        du, dv;
    logic [16:0] vig;
    logic [47:0] nsum;
    logic [32:0] vp;
    logic [31:0] pr, pg, pb2;

    st_d[1]       = st_q[1];
    st_d[1].red   = red_in_i;
    st_d[1].green = green_in_i;
    st_d[1].blue  = blue_in_i;
    st_d[1].satu  = ({1'b0, pixel_col_i} >= wdiv);
    st_d[1].satv  = ({1'b0, pixel_row_i} >= hdiv);
    st_d[1].ru    = {1'b0, pixel_col_i};
    st_d[1].rv    = {1'b0, pixel_row_i};
    st_d[1].qu    = '0;
    st_d[1].qv    = '0;
    st_d[1].wa    = {cpos[7:0], 8'd0};
    st_d[1].wb    = {rpos[7:0], 8'd0};

    for (int k = 2; k <= NST; k++) begin
      st_d[k] = st_q[k-1];
      // Quotient bits for u and v, most significant first
      if (k <= 17) begin
        du = div_step(st_q[k-1].ru, st_q[k-1].qu, wdiv);
        dv = div_step(st_q[k-1].rv, st_q[k-1].qv, hdiv);
        st_d[k].ru = du.rem;
        st_d[k].qu = du.q;
        st_d[k].rv = dv.rem;
        st_d[k].qv = dv.q;
      end
    end

    // Horizontal blend of both noise rows
    st_d[2].r1 = 32'(n11) * 32'(17'h10000 - {1'b0, st_q[1].wa}) +
                 32'(n12) * 32'(st_q[1].wa);
    st_d[2].r2 = 32'(n21) * 32'(17'h10000 - {1'b0, st_q[1].wa}) +
                 32'(n22) * 32'(st_q[1].wa);
    // Vertical blend
    st_d[3].pa = 48'(st_q[2].r1) * 48'(17'h10000 - {1'b0, st_q[2].wb});
    st_d[3].pb = 48'(st_q[2].r2) * 48'(st_q[2].wb);
    nsum       = st_q[3].pa + st_q[3].pb;
    st_d[4].n  = nsum[47:32];
    // (0.9 + 0.1 n) by reciprocal of ten
    st_d[5].sx = 40'(20'd589824 + {4'd0, st_q[4].n}) * 40'(20'd838861);
    st_d[6].s  = st_q[5].sx[38:23];
    // Vignette product
    st_d[18].gu = edge_gain(st_q[17].satu, st_q[17].qu);
    st_d[18].gv = edge_gain(st_q[17].satv, st_q[17].qv);
    st_d[19].t  = 17'((34'(st_q[18].gu) * 34'(st_q[18].gv)) >> 16);
    // Stage 20 waits on the root table read
    vig         = st_q[20].t[16] ? 17'h10000 : {1'b0, vig_rd};
    vp          = 33'(vig) * 33'(st_q[20].s);
    st_d[21].p  = vp[31:16];
    // Channel scaling, then the gamma table read
    pr          = 32'(st_q[21].red)   * 32'(st_q[21].p);
    pg          = 32'(st_q[21].green) * 32'(st_q[21].p);
    pb2         = 32'(st_q[21].blue)  * 32'(st_q[21].p);
    st_d[22].mr = pr[31:16];
    st_d[22].mg = pg[31:16];
    st_d[22].mb = pb2[31:16];
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (adv) st_q <= st_d;
  end

  // Advance valid bits; only pixel requests enter the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-1:1], accept && (cmd_i == CMD_PIXEL)};
    end
  end

  assign out_valid_o = vld_q[NST];

endmodule
